// ===== rtl/fmse_pkg.sv =====
`timescale 1ns / 1ps

package fmse_pkg;

   // Plain frame layout: head, destination, source, type, two old length bytes
   localparam int unsigned HDR_BYTES = 6;
   localparam int unsigned LEN_HI_POS = 4;
   localparam int unsigned XOR_END_POS = 4;

   // Top bits gathered per flag byte
   localparam logic [2:0] GROUP_LAST = 3'd6;

   // Divide by seven: q = (x * DIV7_MUL) >> DIV7_SHIFT, exact for x < 4096
   localparam logic [12:0] DIV7_MUL = 13'd4682;
   localparam int unsigned DIV7_SHIFT = 15;
   // Rounding bias for ceil((len + 2) / 7)
   localparam logic [11:0] LEN_BIAS = 12'd8;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = 2;
   localparam int unsigned QCNT_W = 3;

   // Bytes produced by one accepted input byte, sent in index order
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            end_flag;
      logic            err;
   } entry_type;

endpackage

// ===== rtl/fmse_front.sv =====
`timescale 1ns / 1ps

module fmse_front #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                frame_last,
   input  logic [10:0]         payload_len,
   output fmse_pkg::entry_type entry
);

   localparam int POS_W = $clog2(MAX_PAYLOAD + 8);
   localparam int CMP_W = (POS_W > 11) ? POS_W : 11;
   localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_PAYLOAD + 7);
   localparam logic [POS_W-1:0] POS_HDR = POS_W'(fmse_pkg::HDR_BYTES);
   localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(fmse_pkg::LEN_HI_POS);
   localparam logic [POS_W-1:0] POS_XOR_END = POS_W'(fmse_pkg::XOR_END_POS);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       fill_ff, fill_in;
   logic [6:0]       flags_ff, flags_in;
   logic [7:0]       xor_ff, xor_in;
   logic [10:0]      held_ff, held_in;
   logic [11:0]      coded_len_ff, coded_len_in;

   logic [11:0] len_plus;
   logic [24:0] div_prod;
   logic [8:0]  div_q;
   logic [7:0]  src;
   logic [6:0]  flags_or;
   logic [7:0]  xor_coded;
   logic [7:0]  xor_flag;
   logic        err;

   // Encoded length from the sampled count, registered before use
   assign len_plus = 12'(payload_len) + fmse_pkg::LEN_BIAS;
   assign div_prod = 25'(len_plus) * 25'(fmse_pkg::DIV7_MUL);
   assign div_q = div_prod[fmse_pkg::DIV7_SHIFT +: 9];

   // Select the byte to strip: length bytes or payload
   always_comb begin
      if (pos_ff < POS_HDR) begin
         if (pos_ff == POS_LEN_HI) begin
            src = {4'b0, coded_len_ff[11:8]};
         end else begin
            src = coded_len_ff[7:0];
         end
      end else begin
         src = in_byte;
      end
   end

   assign flags_or = flags_ff | (7'(src[7]) << fill_ff);
   assign xor_coded = xor_ff ^ {1'b0, src[6:0]};
   assign xor_flag = xor_ff ^ {1'b0, flags_ff};

   // Length check at the end byte
   always_comb begin
      if (pos_ff < POS_HDR) begin
         err = 1'b1;
      end else begin
         err = ((CMP_W'(pos_ff) - CMP_W'(POS_HDR)) != CMP_W'(held_ff))
            || (32'(held_ff) > MAX_PAYLOAD);
      end
   end

   // Classify the byte, build its output bytes and next frame state
   always_comb begin
      pos_in = pos_ff;
      fill_in = fill_ff;
      flags_in = flags_ff;
      xor_in = xor_ff;
      held_in = held_ff;
      coded_len_in = coded_len_ff;
      entry = '0;
      if (frame_last) begin
         entry.end_flag = 1'b1;
         entry.err = err;
         if (fill_ff != 3'd0) begin
            entry.count = 2'd3;
            entry.bytes[0] = {1'b0, flags_ff};
            entry.bytes[1] = xor_flag;
            entry.bytes[2] = in_byte;
         end else begin
            entry.count = 2'd2;
            entry.bytes[0] = xor_ff;
            entry.bytes[1] = in_byte;
         end
         pos_in = '0;
         fill_in = '0;
         flags_in = '0;
         xor_in = '0;
         held_in = '0;
      end else begin
         entry.count = 2'd1;
         if (pos_ff == '0) begin
            entry.bytes[0] = in_byte;
            held_in = payload_len;
            coded_len_in = 12'(payload_len) + 12'(div_q);
         end else if (pos_ff < POS_XOR_END) begin
            entry.bytes[0] = in_byte;
            xor_in = xor_ff ^ in_byte;
         end else begin
            entry.bytes[0] = {1'b0, src[6:0]};
            if (fill_ff == fmse_pkg::GROUP_LAST) begin
               // Group complete: flag byte follows at once
               entry.count = 2'd2;
               entry.bytes[1] = {1'b0, flags_or};
               xor_in = xor_coded ^ {1'b0, flags_or};
               fill_in = '0;
               flags_in = '0;
            end else begin
               xor_in = xor_coded;
               fill_in = fill_ff + 3'd1;
               flags_in = flags_or;
            end
         end
         if (pos_ff < POS_SAT) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Hold frame state, advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         fill_ff <= '0;
         flags_ff <= '0;
         xor_ff <= '0;
         held_ff <= '0;
         coded_len_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         fill_ff <= fill_in;
         flags_ff <= flags_in;
         xor_ff <= xor_in;
         held_ff <= held_in;
         coded_len_ff <= coded_len_in;
      end
   end

endmodule

// ===== rtl/fmse_queue.sv =====
`timescale 1ns / 1ps

module fmse_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fmse_pkg::entry_type push_data,
   input  logic                pop,
   output fmse_pkg::entry_type head,
   output logic                not_empty,
   output logic                full
);

   fmse_pkg::entry_type slots_ff [fmse_pkg::QUEUE_DEPTH];
   logic [fmse_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [fmse_pkg::QCNT_W-1:0] count_ff;

   assign not_empty = (count_ff != '0);
   assign full = (count_ff == fmse_pkg::QCNT_W'(fmse_pkg::QUEUE_DEPTH));
   assign head = slots_ff[rd_ptr_ff];

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue pop while empty");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == fmse_pkg::QPTR_W'(count_ff))
      else $error("queue pointers disagree with count");

endmodule

// ===== rtl/fmse_back.sv =====
`timescale 1ns / 1ps

module fmse_back (
   input  logic                clock,
   input  logic                reset,
   input  fmse_pkg::entry_type head,
   input  logic                not_empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_run_last,
   output logic                rsp_frame_done,
   output logic                rsp_length_error
);

   logic [1:0] idx_ff, idx_in;
   logic       last_of;
   logic       fire;

   assign rsp_valid = not_empty;
   assign last_of = (idx_ff == (head.count - 2'd1));
   assign fire = rsp_valid && rsp_ready;
   assign pop = fire && last_of;

   // Present the current byte of the head entry
   assign rsp_out_byte = head.bytes[idx_ff];
   assign rsp_run_last = last_of;
   assign rsp_frame_done = head.end_flag && last_of;
   assign rsp_length_error = head.err && last_of;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = last_of ? 2'd0 : (idx_ff + 2'd1);
      end
   end

   // Step through the bytes of the head entry
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      not_empty |-> (head.count != 2'd0))
      else $error("queued entry holds no bytes");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      not_empty |-> (idx_ff < head.count))
      else $error("byte index beyond entry");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte)))
      else $error("output transaction changed while stalled");

endmodule

// ===== rtl/frame_msb_strip_encoder.sv =====
`timescale 1ns / 1ps

// Frame encoder with top-bit stripping.
// Input channel (req_*): one plain frame byte per transaction, with
// req_frame_last on the end byte and req_payload_len sampled on the first
// byte of each frame. Output channel (rsp_*): encoded bytes; rsp_run_last
// marks the final byte caused by an input byte, rsp_frame_done the end byte,
// and rsp_length_error is valid on the end byte.
// Each input byte yields one, two or three output bytes. The front stage
// classifies the byte and updates the frame state in the accepting cycle;
// the bytes enter a four-entry queue, and rsp_* presents the head entry.
// The input takes one byte per cycle while the queue has room; output runs
// at one byte per cycle while the receiver is ready, so the sustained rate
// is set by the output side and by how many bytes each input byte yields.
// When the receiver stalls, the queue fills and req_ready drops.
// Reset clears the frame state and empties the queue; the next byte starts
// a new frame.

module frame_msb_strip_encoder #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_last,
   input  logic [10:0] req_payload_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_done,
   output logic        rsp_length_error
);

   fmse_pkg::entry_type entry;
   fmse_pkg::entry_type head;
   logic                accept;
   logic                pop;
   logic                not_empty;
   logic                full;

   assign req_ready = !full;
   assign accept = req_valid && req_ready;

   fmse_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .frame_last  (req_frame_last),
      .payload_len (req_payload_len),
      .entry       (entry)
   );

   fmse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (entry),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   fmse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .not_empty        (not_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_length_error (rsp_length_error)
   );

endmodule
